// ===== rtl/hfe_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hfe_pkg
// Shared types and constants of the HDLC frame bit encoder: microcode
// format, configuration bundle and the links between sequencer and datapath.
// ---------------------------------------------------------------------------
package hfe_pkg;

    localparam int STEP_W     = 4;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // configuration register indexes
    localparam cfg_idx_t REG_PREAMBLE_FLAGS = 2'd0;
    localparam cfg_idx_t REG_USE_SCRAMBLER  = 2'd1;
    localparam cfg_idx_t REG_SCRAMBLER_SEED = 2'd2;
    localparam cfg_idx_t REG_INVERT_OUTPUT  = 2'd3;

    localparam logic [5:0]  PREAMBLE_RESET = 6'd8;
    localparam logic [5:0]  MAX_PREAMBLE   = 6'd32;
    localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h8408;
    // a fifth one in a row triggers the inserted zero
    localparam logic [2:0]  ONES_BEFORE_STUFF = 3'd4;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_INIT,
        OP_NOP,
        OP_FLAG,
        OP_DATA,
        OP_FCS_LO,
        OP_FCS_HI,
        OP_PAD
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_FIRST,
        COND_NO_FLAGS,
        COND_NOT_LAST,
        COND_SCRAMBLER
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  end_if_scr;
        logic  end_always;
    } ctl_t;

    typedef struct packed {
        logic [5:0]  preamble_flags;
        logic        use_scrambler;
        logic [16:0] scrambler_seed;
        logic        invert_output;
    } cfg_t;

    typedef struct packed {
        logic done;
        logic no_flags;
    } dp_status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       frame_end;
    } emit_t;

    // program addresses
    localparam step_t S_ACCEPT   = 4'd0;
    localparam step_t S_INIT     = 4'd1;
    localparam step_t S_PRE_TEST = 4'd2;
    localparam step_t S_PRE_FLAG = 4'd3;
    localparam step_t S_DATA     = 4'd4;
    localparam step_t S_FCS_LO   = 4'd5;
    localparam step_t S_FCS_HI   = 4'd6;
    localparam step_t S_CLOSE_1  = 4'd7;
    localparam step_t S_CLOSE_2  = 4'd8;
    localparam step_t S_PAD      = 4'd9;

endpackage

`default_nettype wire

// ===== rtl/hfe_ucode_rom.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hfe_ucode_rom
// Control store of the encoder: one control word per program step.
// ---------------------------------------------------------------------------
module hfe_ucode_rom (
    input  wire hfe_pkg::step_t addr,
    output hfe_pkg::ctl_t       word
);
    import hfe_pkg::*;

    always_comb
    begin
        word = '{op: OP_NOP, cond: COND_ALWAYS, target: S_ACCEPT,
                 end_if_scr: 1'b0, end_always: 1'b0};
        unique case (addr)
            S_ACCEPT:   begin word.op = OP_ACCEPT; word.cond = COND_NOT_FIRST;
                              word.target = S_DATA; end
            S_INIT:     begin word.op = OP_INIT;   word.cond = COND_NEVER; end
            S_PRE_TEST: begin word.op = OP_NOP;    word.cond = COND_NO_FLAGS;
                              word.target = S_DATA; end
            S_PRE_FLAG: begin word.op = OP_FLAG;   word.cond = COND_ALWAYS;
                              word.target = S_PRE_TEST; end
            S_DATA:     begin word.op = OP_DATA;   word.cond = COND_NOT_LAST;
                              word.target = S_ACCEPT; end
            S_FCS_LO:   begin word.op = OP_FCS_LO; word.cond = COND_NEVER; end
            S_FCS_HI:   begin word.op = OP_FCS_HI; word.cond = COND_NEVER; end
            // scrambler mode closes with a single flag
            S_CLOSE_1:  begin word.op = OP_FLAG;   word.cond = COND_SCRAMBLER;
                              word.target = S_PAD; word.end_if_scr = 1'b1; end
            S_CLOSE_2:  begin word.op = OP_FLAG;   word.cond = COND_NEVER;
                              word.end_always = 1'b1; end
            S_PAD:      begin word.op = OP_PAD;    word.cond = COND_ALWAYS;
                              word.target = S_ACCEPT; end
            default:    begin word.op = OP_NOP;    word.cond = COND_ALWAYS;
                              word.target = S_ACCEPT; end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/hfe_sequencer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hfe_sequencer
// Step counter with conditional jumps over the control store.
// ---------------------------------------------------------------------------
module hfe_sequencer (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_fire,
    input  wire                     first_in,
    input  wire                     last_hold,
    input  wire                     use_scrambler,
    input  wire hfe_pkg::dp_status_t status,
    output hfe_pkg::ctl_t           ctl,
    output logic                    accept_step
);
    import hfe_pkg::*;

    step_t upc_reg;
    step_t upc_next;
    logic  advance;
    logic  cond_true;

    hfe_ucode_rom u_rom (
        .addr (upc_reg),
        .word (ctl)
    );

    assign accept_step = (ctl.op == OP_ACCEPT);

    always_comb
    begin
        case (ctl.cond)
            COND_NEVER:     cond_true = 1'b0;
            COND_ALWAYS:    cond_true = 1'b1;
            COND_NOT_FIRST: cond_true = !first_in;
            COND_NO_FLAGS:  cond_true = status.no_flags;
            COND_NOT_LAST:  cond_true = !last_hold;
            COND_SCRAMBLER: cond_true = use_scrambler;
            default:        cond_true = 1'b0;
        endcase
        advance  = accept_step ? in_fire : status.done;
        upc_next = upc_reg;
        if (advance)
        begin
            upc_next = cond_true ? ctl.target : upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_ACCEPT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hfe_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hfe_datapath
// Bit engine: bit select, zero insertion, serial CRC, scrambler or NRZI,
// and the MSB-first packer that hands finished bytes to the output stage.
// ---------------------------------------------------------------------------
module hfe_datapath (
    input  wire                clk,
    input  wire                rst_n,
    input  wire hfe_pkg::ctl_t ctl,
    input  wire hfe_pkg::cfg_t cfg,
    input  wire [7:0]          data_hold,
    input  wire                can_emit,
    output hfe_pkg::dp_status_t status,
    output hfe_pkg::emit_t      emit
);
    import hfe_pkg::*;

    logic [15:0] crc_reg,        crc_next;
    logic [2:0]  ones_run_reg,   ones_run_next;
    logic        nrzi_reg,       nrzi_next;
    logic [16:0] scr_reg,        scr_next;
    logic [7:0]  pack_shift_reg, pack_shift_next;
    logic [2:0]  pack_cnt_reg,   pack_cnt_next;
    logic [2:0]  bit_cnt_reg,    bit_cnt_next;
    logic        stuff_pend_reg, stuff_pend_next;
    logic [5:0]  flag_cnt_reg,   flag_cnt_next;

    logic [7:0]  src_byte;
    logic        stuffed_op;
    logic        raw_bit;
    logic        scr_bit;
    logic        nrzi_new;
    logic        line_bit;
    logic        need_stuff;
    logic        bit_stall;
    logic        crc_fb;
    logic        close_end;
    logic [2:0]  pad_shift;

    always_comb
    begin
        case (ctl.op)
            OP_DATA:   src_byte = data_hold;
            OP_FCS_LO: src_byte = ~crc_reg[7:0];
            OP_FCS_HI: src_byte = ~crc_reg[15:8];
            default:   src_byte = FLAG_BYTE;
        endcase
    end

    assign stuffed_op = (ctl.op == OP_DATA) || (ctl.op == OP_FCS_LO) ||
                        (ctl.op == OP_FCS_HI);
    assign raw_bit    = stuff_pend_reg ? 1'b0 : src_byte[bit_cnt_reg];
    assign scr_bit    = raw_bit ^ scr_reg[16] ^ scr_reg[11];
    assign nrzi_new   = raw_bit ? nrzi_reg : ~nrzi_reg;
    assign line_bit   = (cfg.use_scrambler ? scr_bit : nrzi_new) ^ cfg.invert_output;
    assign need_stuff = stuffed_op && !stuff_pend_reg && raw_bit &&
                        (ones_run_reg == ONES_BEFORE_STUFF);
    // a bit that completes a byte waits for room in the output stage
    assign bit_stall  = (pack_cnt_reg == 3'd7) && !can_emit;
    assign crc_fb     = crc_reg[0] ^ raw_bit;
    assign close_end  = ctl.end_always || (ctl.end_if_scr && cfg.use_scrambler);
    assign pad_shift  = 3'd0 - pack_cnt_reg;

    always_comb
    begin
        crc_next        = crc_reg;
        ones_run_next   = ones_run_reg;
        nrzi_next       = nrzi_reg;
        scr_next        = scr_reg;
        pack_shift_next = pack_shift_reg;
        pack_cnt_next   = pack_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        stuff_pend_next = stuff_pend_reg;
        flag_cnt_next   = flag_cnt_reg;
        status.done     = 1'b0;
        status.no_flags = (flag_cnt_reg == 6'd0);
        emit            = '0;

        unique case (ctl.op)
            OP_INIT:
            begin
                crc_next        = CRC_INIT;
                ones_run_next   = 3'd0;
                nrzi_next       = 1'b0;
                scr_next        = cfg.scrambler_seed;
                pack_shift_next = 8'd0;
                pack_cnt_next   = 3'd0;
                bit_cnt_next    = 3'd0;
                stuff_pend_next = 1'b0;
                flag_cnt_next   = (cfg.preamble_flags > MAX_PREAMBLE) ?
                                  MAX_PREAMBLE : cfg.preamble_flags;
                status.done     = 1'b1;
            end
            OP_NOP:
            begin
                status.done = 1'b1;
            end
            OP_FLAG, OP_DATA, OP_FCS_LO, OP_FCS_HI:
            begin
                if (!bit_stall)
                begin
                    // line coding
                    if (cfg.use_scrambler)
                    begin
                        scr_next = {scr_reg[15:0], scr_bit};
                    end
                    else
                    begin
                        nrzi_next = nrzi_new;
                    end
                    // packer
                    if (pack_cnt_reg == 3'd7)
                    begin
                        emit.valid      = 1'b1;
                        emit.data       = {pack_shift_reg[6:0], line_bit};
                        emit.frame_end  = close_end && (ctl.op == OP_FLAG) &&
                                          (bit_cnt_reg == 3'd7);
                        pack_shift_next = 8'd0;
                        pack_cnt_next   = 3'd0;
                    end
                    else
                    begin
                        pack_shift_next = {pack_shift_reg[6:0], line_bit};
                        pack_cnt_next   = pack_cnt_reg + 3'd1;
                    end
                    // bit position and zero insertion
                    if (stuff_pend_reg)
                    begin
                        stuff_pend_next = 1'b0;
                        ones_run_next   = 3'd0;
                        bit_cnt_next    = bit_cnt_reg + 3'd1;
                        status.done     = (bit_cnt_reg == 3'd7);
                    end
                    else
                    begin
                        if (ctl.op == OP_DATA)
                        begin
                            crc_next = {1'b0, crc_reg[15:1]} ^ (crc_fb ? CRC_POLY : 16'd0);
                        end
                        if (stuffed_op)
                        begin
                            if (!raw_bit)
                            begin
                                ones_run_next = 3'd0;
                            end
                            else if (need_stuff)
                            begin
                                ones_run_next = 3'd0;
                            end
                            else
                            begin
                                ones_run_next = ones_run_reg + 3'd1;
                            end
                        end
                        if (need_stuff)
                        begin
                            stuff_pend_next = 1'b1;
                        end
                        else
                        begin
                            bit_cnt_next = bit_cnt_reg + 3'd1;
                            status.done  = (bit_cnt_reg == 3'd7);
                        end
                    end
                    if ((ctl.op == OP_FLAG) && status.done && !status.no_flags)
                    begin
                        flag_cnt_next = flag_cnt_reg - 6'd1;
                    end
                end
            end
            OP_PAD:
            begin
                if (pack_cnt_reg == 3'd0)
                begin
                    status.done = 1'b1;
                end
                else if (can_emit)
                begin
                    // pad bits are plain zeros
                    emit.valid      = 1'b1;
                    emit.data       = pack_shift_reg << pad_shift;
                    emit.frame_end  = 1'b1;
                    pack_shift_next = 8'd0;
                    pack_cnt_next   = 3'd0;
                    status.done     = 1'b1;
                end
            end
            default:
            begin
                status.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= CRC_INIT;
            ones_run_reg   <= 3'd0;
            nrzi_reg       <= 1'b0;
            scr_reg        <= 17'd0;
            pack_shift_reg <= 8'd0;
            pack_cnt_reg   <= 3'd0;
            bit_cnt_reg    <= 3'd0;
            stuff_pend_reg <= 1'b0;
            flag_cnt_reg   <= 6'd0;
        end
        else
        begin
            crc_reg        <= crc_next;
            ones_run_reg   <= ones_run_next;
            nrzi_reg       <= nrzi_next;
            scr_reg        <= scr_next;
            pack_shift_reg <= pack_shift_next;
            pack_cnt_reg   <= pack_cnt_next;
            bit_cnt_reg    <= bit_cnt_next;
            stuff_pend_reg <= stuff_pend_next;
            flag_cnt_reg   <= flag_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hdlc_frame_bit_encoder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hdlc_frame_bit_encoder
// HDLC frame transmitter with zero insertion, CRC-16 FCS and NRZI or
// G3RUH line coding; line bits leave packed MSB first, one byte per transaction.
// ---------------------------------------------------------------------------
// One frame byte is taken per input transaction, and no new byte is taken
// until its line bits are produced. The bit engine makes one line bit per
// clock while the output stage has room; a plain byte takes an acceptance
// step, 8 bits and at most two inserted zeros. A first byte adds setup (the
// init and preamble test steps) plus a flag and a test step per preamble
// flag; a last byte adds the FCS, one or two closing flags (two in NRZI
// mode) and one pad step. A bit that finishes a byte while the output
// register is still full stalls the engine until there is room.
// Configuration writes are taken every cycle and must only be made while
// the encoder is idle.
module hdlc_frame_bit_encoder (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire [7:0]             data_byte,
    input  wire                   first_byte,
    input  wire                   last_byte,
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic [7:0]            out_byte,
    output logic                  frame_end,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire hfe_pkg::cfg_idx_t  cfg_index,
    input  wire hfe_pkg::cfg_data_t cfg_data
);
    import hfe_pkg::*;

    cfg_t       cfg_reg;
    logic [7:0] data_hold_reg;
    logic       last_hold_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       frame_end_reg;

    ctl_t       ctl;
    dp_status_t status;
    emit_t      emit;
    logic       accept_step;
    logic       in_fire;
    logic       can_emit;

    assign in_ready  = accept_step;
    assign in_fire   = in_valid && accept_step;
    assign cfg_ready = 1'b1;
    assign can_emit  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

    hfe_sequencer u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .first_in      (first_byte),
        .last_hold     (last_hold_reg),
        .use_scrambler (cfg_reg.use_scrambler),
        .status        (status),
        .ctl           (ctl),
        .accept_step   (accept_step)
    );

    hfe_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg       (cfg_reg),
        .data_hold (data_hold_reg),
        .can_emit  (can_emit),
        .status    (status),
        .emit      (emit)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_flags <= PREAMBLE_RESET;
            cfg_reg.use_scrambler  <= 1'b0;
            cfg_reg.scrambler_seed <= 17'd0;
            cfg_reg.invert_output  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PREAMBLE_FLAGS: cfg_reg.preamble_flags <= cfg_data[5:0];
                REG_USE_SCRAMBLER:  cfg_reg.use_scrambler  <= cfg_data[0];
                REG_SCRAMBLER_SEED: cfg_reg.scrambler_seed <= cfg_data[16:0];
                REG_INVERT_OUTPUT:  cfg_reg.invert_output  <= cfg_data[0];
                default:            cfg_reg.invert_output  <= cfg_reg.invert_output;
            endcase
        end
    end

    // input byte held for the whole item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            data_hold_reg <= data_byte;
            last_hold_reg <= last_byte;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_byte_reg  <= emit.data;
            frame_end_reg <= emit.frame_end;
        end
    end

    // a finished byte never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> (!out_valid_reg || out_ready))
        else $error("output byte overwritten while pending");

    // frame end only comes from a closing flag or the pad step
    a_end_source: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.frame_end) |-> (ctl.op == OP_FLAG || ctl.op == OP_PAD))
        else $error("frame end marked outside the trailer");

    // an accepted byte goes to setup or straight to the data step
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (ctl.op == OP_INIT || ctl.op == OP_DATA))
        else $error("bad step after input transaction");

endmodule

`default_nettype wire
